// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that a condition at one edge is followed by another at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ccsort_pkg.sv -----
// Shared widths and defaults of the comparison counting sort unit.
package ccsort_pkg;

    // Width of one sorted value.
    localparam int DATA_W = 32;

    // Default and largest capacity of the element store.
    localparam int MAX_ITEMS_DEF = 64;
    localparam int MAX_ITEMS_CAP = 64;

endpackage

// ----- rtl/ccsort_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module ccsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and read the addressed entry into the output register.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/comparison_counting_sort_unit.sv -----
// Stable comparison counting sort: a new item is compared against every stored value with one
// shared signed comparator, one stored value per cycle, while the block is not ready. The
// compare pass is paced by the single read port of the value and rank memories, which delivers
// one stored value and its rank each cycle; after it the item's own rank is written back and
// the block is ready again. An item arriving with the store full is dropped and flags overflow
// on the set. After the item marked last, the n values are placed by rank into a sorted memory;
// then each result is read (S_ERD), loaded into the output register (S_ELD) and held in S_EOUT
// until m_tready. Equal values leave in arrival order.
`include "assert_macros.svh"

module comparison_counting_sort_unit #(
    parameter int MAX_ITEMS = ccsort_pkg::MAX_ITEMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccsort_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                          s_tlast,  // last_in
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccsort_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
    output logic                          m_tlast,  // last_out
    output logic                          m_tuser   // [0] overflow
);

    localparam int DW = ccsort_pkg::DATA_W;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FIN,
        S_SCAT,
        S_ERD,
        S_ELD,
        S_EOUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [DW-1:0]   new_val_reg, new_val_next;
    logic            last_reg, last_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;
    logic [AW-1:0]   own_rank_reg, own_rank_next;
    logic            m_valid_reg, m_valid_next;
    logic [DW-1:0]   m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            m_user_reg, m_user_next;

    // Memory ports.
    logic            val_we;
    logic [AW-1:0]   val_waddr;
    logic [DW-1:0]   val_rdata;
    logic            rank_we;
    logic [AW-1:0]   rank_waddr;
    logic [AW-1:0]   rank_wdata;
    logic [AW-1:0]   rank_rdata;
    logic            srt_we;
    logic [DW-1:0]   srt_rdata;
    logic            s_accept;
    logic            is_less;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Shared comparator: new value against the stored value read last cycle.
    assign is_less = $signed(new_val_reg) < $signed(val_rdata);

    ccsort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (s_tdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (val_rdata)
    );

    ccsort_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_waddr),
        .wr_data (rank_wdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rank_rdata)
    );

    ccsort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_srt_ram (
        .aclk    (aclk),
        .wr_en   (srt_we),
        .wr_addr (rank_rdata),
        .wr_data (val_rdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (srt_rdata)
    );

    // Sequencer: compare pass, rank write-back, scatter by rank, then emit.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        new_val_next  = new_val_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        own_rank_next = own_rank_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_user_next   = m_user_reg;
        val_we        = 1'b0;
        val_waddr     = cnt_reg[AW-1:0];
        rank_we       = 1'b0;
        rank_waddr    = pend_idx_reg;
        rank_wdata    = AW'(rank_rdata + 1'b1);
        srt_we        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    last_next = s_tlast;
                    idx_next  = '0;
                    if (cnt_reg < CW'(MAX_ITEMS)) begin
                        val_we        = 1'b1;
                        new_val_next  = s_tdata;
                        own_rank_next = '0;
                        state_next    = S_CMP;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            state_next = S_SCAT;
                        end
                    end
                end
            end
            S_CMP: begin
                // Result of the read issued last cycle.
                if (pend_reg) begin
                    if (is_less) begin
                        rank_we = 1'b1;
                    end else begin
                        own_rank_next = own_rank_reg + 1'b1;
                    end
                end
                if (idx_reg < cnt_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                rank_we    = 1'b1;
                rank_waddr = cnt_reg[AW-1:0];
                rank_wdata = own_rank_reg;
                cnt_next   = cnt_reg + 1'b1;
                idx_next   = '0;
                state_next = last_reg ? S_SCAT : S_IDLE;
            end
            S_SCAT: begin
                // Place the value read last cycle at the slot given by its rank.
                srt_we = pend_reg;
                if (idx_reg < cnt_reg) begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD: begin
                state_next = S_ELD;
            end
            S_ELD: begin
                m_valid_next = 1'b1;
                m_data_next  = srt_rdata;
                m_last_next  = (CW'(idx_reg + 1'b1) == cnt_reg);
                m_user_next  = ovf_reg;
                state_next   = S_EOUT;
            end
            S_EOUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        new_val_reg  <= new_val_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        own_rank_reg <= own_rank_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // The store never holds more than its capacity.
    `ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CW'(MAX_ITEMS), "item count beyond capacity")
    // No input item is taken while a result is on offer.
    `ASSERT_ALWAYS(a_busy_emit, !(m_tvalid && s_tready), "input ready while emitting")
    // A pending memory read only exists during the compare or scatter pass.
    `ASSERT_ALWAYS(a_pend_state, !pend_reg || state_reg == S_CMP || state_reg == S_SCAT,
                   "pending read outside a pass")
    // Delivering the final result starts a fresh set.
    `ASSERT_NEXT(a_set_clear, m_tvalid && m_tready && m_tlast,
                 cnt_reg == '0 && !ovf_reg && s_tready, "set not cleared after final result")

endmodule
